@@ design/mecanum_wheel_mixer_normalized_top_assert.svh @@
// ---------------------------------------------------------------------------
// Mecanum mixer assertion macros
// Concurrent assertion shorthands shared by the mixer RTL.
// ---------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_MIXER_NORMALIZED_TOP_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_NORMALIZED_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MWM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mixer assertion failed");

// Next-cycle implication, disabled during reset.
`define MWM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mixer assertion failed");

`endif

@@ design/mwm_pkg.sv @@
// ---------------------------------------------------------------------------
// Mecanum mixer package
// Field widths, register indexes, reset values and the result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwm_pkg;

   localparam int VEL_W    = 16;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int WHEEL_W  = 16;
   localparam int WHEELS   = 4;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // velocity times gain, and that times the rotation coefficient
   localparam int PROD_W = VEL_W + GAIN_W;
   localparam int YAW_W  = PROD_W + GAIN_W;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_GAIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_COEFF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT    = 2'd2;

   localparam logic [GAIN_W-1:0]  AXIS_GAIN_RESET      = 16'd256;
   localparam logic [GAIN_W-1:0]  ROTATION_COEFF_RESET = 16'd256;
   localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET    = 15'd8000;

   typedef struct packed {
      logic [WHEELS-1:0][WHEEL_W-1:0] wheel;
      logic                           was_scaled;
   } result_type;

endpackage

@@ design/mecanum_wheel_mixer_normalized_top.sv @@
// ---------------------------------------------------------------------------
// Mecanum wheel mixer with desaturation
// Chassis velocity in, four limited wheel speeds out, fully pipelined.
// ---------------------------------------------------------------------------
// A request (vel_x, vel_y, yaw_rate) is scaled by the Q-format axis gain, the
// yaw term also by the rotation coefficient, and mixed into four wheel speeds
// (+x+y, -x+y, +x-y, -x-y, each plus yaw). When the largest wheel magnitude
// is above speed_limit, every wheel is scaled by limit/max (toward zero) and
// was_scaled is set. The block takes one request per cycle while req_stall is
// low and returns one response per request, in order. The path from acceptance
// to rsp_valid is six stages of multiply, mix, magnitude and max, one stage that
// forms wheel*limit, then a 15-stage restoring divider that retires one
// quotient bit per stage (one stage per bit of speed_limit), then the output
// register. A two-entry output (register plus skid) keeps req_stall a
// registered signal; it rises only after a response has waited on rsp_stall
// long enough for the skid entry to fill. Write the CSRs only while idle.
`timescale 1ns / 1ps

module mecanum_wheel_mixer_normalized_top #(
   parameter int COEFF_FRACTION_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [mwm_pkg::VEL_W-1:0]      req_vel_x,
   input  logic signed [mwm_pkg::VEL_W-1:0]      req_vel_y,
   input  logic signed [mwm_pkg::VEL_W-1:0]      req_yaw_rate,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_one,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_two,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_three,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_four,
   output logic                                  rsp_was_scaled,
   // configuration write port
   input  logic                                  csr_write_en,
   input  logic [mwm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mwm_pkg::CSR_W-1:0]             csr_data
);
   import mwm_pkg::*;

   `include "mecanum_wheel_mixer_normalized_top_assert.svh"

   localparam int F = COEFF_FRACTION_BITS;
   // |x*g*2^F| + |y*g*2^F| + |yaw*g*rc| stays below 2^MAG_W
   localparam int MAG_W = ((PROD_W + F > YAW_W - 1) ? PROD_W + F : YAW_W - 1) + 1;
   localparam int SUM_W = MAG_W + 1;
   localparam int NUM_W = MAG_W + LIMIT_W;
   localparam int DIV_STEPS = LIMIT_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [GAIN_W-1:0]  axis_gain_ff;
   logic [GAIN_W-1:0]  rotation_coeff_ff;
   logic [LIMIT_W-1:0] speed_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_gain_ff      <= AXIS_GAIN_RESET;
         rotation_coeff_ff <= ROTATION_COEFF_RESET;
         speed_limit_ff    <= SPEED_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_AXIS_GAIN:      axis_gain_ff      <= csr_data[GAIN_W-1:0];
            CSR_ROTATION_COEFF: rotation_coeff_ff <= csr_data[GAIN_W-1:0];
            CSR_SPEED_LIMIT:    speed_limit_ff    <= csr_data[LIMIT_W-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: every stage advances while the skid entry is free
   // ------------------------------------------------------------------
   logic advance;
   logic skid_valid_ff;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ------------------------------------------------------------------
   // Stage 1: velocity times axis gain
   // ------------------------------------------------------------------
   logic                     s1_valid_ff;
   logic signed [PROD_W:0]   s1_px_in, s1_py_in, s1_pw_in;
   logic signed [PROD_W-1:0] s1_px_ff, s1_py_ff, s1_pw_ff;

   assign s1_px_in = $signed(req_vel_x)    * $signed({1'b0, axis_gain_ff});
   assign s1_py_in = $signed(req_vel_y)    * $signed({1'b0, axis_gain_ff});
   assign s1_pw_in = $signed(req_yaw_rate) * $signed({1'b0, axis_gain_ff});

   // ------------------------------------------------------------------
   // Stage 2: yaw term times rotation coefficient
   // ------------------------------------------------------------------
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_px_ff, s2_py_ff;
   logic signed [YAW_W:0]    s2_yaw_in;
   logic signed [YAW_W-1:0]  s2_yaw_ff;

   assign s2_yaw_in = s1_pw_ff * $signed({1'b0, rotation_coeff_ff});

   // ------------------------------------------------------------------
   // Stage 3: mix into four wheel values in units of 2^-2F
   // ------------------------------------------------------------------
   logic                    s3_valid_ff;
   logic signed [SUM_W-1:0] s3_gx, s3_gy, s3_yaw;
   logic signed [SUM_W-1:0] s3_w_in [WHEELS];
   logic signed [SUM_W-1:0] s3_w_ff [WHEELS];

   assign s3_gx  = $signed({{(SUM_W - PROD_W){s2_px_ff[PROD_W-1]}}, s2_px_ff}) <<< F;
   assign s3_gy  = $signed({{(SUM_W - PROD_W){s2_py_ff[PROD_W-1]}}, s2_py_ff}) <<< F;
   assign s3_yaw = $signed({{(SUM_W - YAW_W){s2_yaw_ff[YAW_W-1]}}, s2_yaw_ff});

   assign s3_w_in[0] =  s3_gx + s3_gy + s3_yaw;
   assign s3_w_in[1] = -s3_gx + s3_gy + s3_yaw;
   assign s3_w_in[2] =  s3_gx - s3_gy + s3_yaw;
   assign s3_w_in[3] = -s3_gx - s3_gy + s3_yaw;

   // ------------------------------------------------------------------
   // Stage 4: split into sign and magnitude
   // ------------------------------------------------------------------
   logic                    s4_valid_ff;
   logic [SUM_W-1:0]        s4_abs [WHEELS];
   logic [MAG_W-1:0]        s4_mag_ff [WHEELS];
   logic [WHEELS-1:0]       s4_neg_ff;

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         s4_abs[i] = s3_w_ff[i][SUM_W-1] ? SUM_W'(-s3_w_ff[i]) : SUM_W'(s3_w_ff[i]);
      end
   end

   // ------------------------------------------------------------------
   // Stages 5 and 6: registered max tree over the four magnitudes
   // ------------------------------------------------------------------
   logic              s5_valid_ff;
   logic [MAG_W-1:0]  s5_mag_ff [WHEELS];
   logic [WHEELS-1:0] s5_neg_ff;
   logic [MAG_W-1:0]  s5_pmax_in [2];
   logic [MAG_W-1:0]  s5_pmax_ff [2];

   assign s5_pmax_in[0] = (s4_mag_ff[0] > s4_mag_ff[1]) ? s4_mag_ff[0] : s4_mag_ff[1];
   assign s5_pmax_in[1] = (s4_mag_ff[2] > s4_mag_ff[3]) ? s4_mag_ff[2] : s4_mag_ff[3];

   logic              s6_valid_ff;
   logic [MAG_W-1:0]  s6_mag_ff [WHEELS];
   logic [WHEELS-1:0] s6_neg_ff;
   logic [MAG_W-1:0]  s6_max_in, s6_max_ff;

   assign s6_max_in = (s5_pmax_ff[0] > s5_pmax_ff[1]) ? s5_pmax_ff[0] : s5_pmax_ff[1];

   // ------------------------------------------------------------------
   // Divider: entry 0 is loaded with wheel*limit split into a partial
   // remainder (upper bits) and the dividend bits still to shift in; each
   // following entry retires one quotient bit per wheel.
   // ------------------------------------------------------------------
   logic [MAG_W-1:0]   lim_wide;
   logic [NUM_W-1:0]   num [WHEELS];

   logic               dv_in     [DIV_STEPS+1];
   logic               dv_ff     [DIV_STEPS+1];
   logic               scale_in  [DIV_STEPS+1];
   logic               scale_ff  [DIV_STEPS+1];
   logic [MAG_W-1:0]   den_in    [DIV_STEPS+1];
   logic [MAG_W-1:0]   den_ff    [DIV_STEPS+1];
   logic [WHEELS-1:0]  neg_in    [DIV_STEPS+1];
   logic [WHEELS-1:0]  neg_ff    [DIV_STEPS+1];
   logic [MAG_W-1:0]   rem_in    [DIV_STEPS+1][WHEELS];
   logic [MAG_W-1:0]   rem_ff    [DIV_STEPS+1][WHEELS];
   logic [LIMIT_W-1:0] acc_in    [DIV_STEPS+1][WHEELS];
   logic [LIMIT_W-1:0] acc_ff    [DIV_STEPS+1][WHEELS];
   logic [LIMIT_W-1:0] trunc_in  [DIV_STEPS+1][WHEELS];
   logic [LIMIT_W-1:0] trunc_ff  [DIV_STEPS+1][WHEELS];
   logic [MAG_W:0]     trial     [DIV_STEPS][WHEELS];
   logic [MAG_W:0]     diff      [DIV_STEPS][WHEELS];

   assign lim_wide = MAG_W'(speed_limit_ff) << (2 * F);

   always_comb begin
      // load: scale decision, numerator, and the unscaled fallback
      dv_in[0]    = s6_valid_ff;
      scale_in[0] = s6_max_ff > lim_wide;
      den_in[0]   = s6_max_ff;
      neg_in[0]   = s6_neg_ff;
      for (int i = 0; i < WHEELS; i++) begin
         num[i]         = NUM_W'(s6_mag_ff[i]) * NUM_W'(speed_limit_ff);
         rem_in[0][i]   = num[i][NUM_W-1:LIMIT_W];
         acc_in[0][i]   = num[i][LIMIT_W-1:0];
         trunc_in[0][i] = s6_mag_ff[i][2*F+LIMIT_W-1:2*F];
      end
      // one restoring step per stage
      for (int k = 0; k < DIV_STEPS; k++) begin
         dv_in[k+1]    = dv_ff[k];
         scale_in[k+1] = scale_ff[k];
         den_in[k+1]   = den_ff[k];
         neg_in[k+1]   = neg_ff[k];
         for (int i = 0; i < WHEELS; i++) begin
            trial[k][i] = {rem_ff[k][i], acc_ff[k][i][LIMIT_W-1]};
            diff[k][i]  = trial[k][i] - {1'b0, den_ff[k]};
            if (trial[k][i] >= {1'b0, den_ff[k]}) begin
               rem_in[k+1][i] = diff[k][i][MAG_W-1:0];
               acc_in[k+1][i] = {acc_ff[k][i][LIMIT_W-2:0], 1'b1};
            end else begin
               rem_in[k+1][i] = trial[k][i][MAG_W-1:0];
               acc_in[k+1][i] = {acc_ff[k][i][LIMIT_W-2:0], 1'b0};
            end
            trunc_in[k+1][i] = trunc_ff[k][i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Pipeline registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff  <= s1_px_in[PROD_W-1:0];
         s1_py_ff  <= s1_py_in[PROD_W-1:0];
         s1_pw_ff  <= s1_pw_in[PROD_W-1:0];
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_yaw_ff <= s2_yaw_in[YAW_W-1:0];
         for (int i = 0; i < WHEELS; i++) begin
            s3_w_ff[i]   <= s3_w_in[i];
            s4_mag_ff[i] <= s4_abs[i][MAG_W-1:0];
            s4_neg_ff[i] <= s3_w_ff[i][SUM_W-1];
            s5_mag_ff[i] <= s4_mag_ff[i];
            s6_mag_ff[i] <= s5_mag_ff[i];
         end
         s5_neg_ff     <= s4_neg_ff;
         s5_pmax_ff[0] <= s5_pmax_in[0];
         s5_pmax_ff[1] <= s5_pmax_in[1];
         s6_neg_ff     <= s5_neg_ff;
         s6_max_ff     <= s6_max_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            scale_ff[k] <= scale_in[k];
            den_ff[k]   <= den_in[k];
            neg_ff[k]   <= neg_in[k];
            for (int i = 0; i < WHEELS; i++) begin
               rem_ff[k][i]   <= rem_in[k][i];
               acc_ff[k][i]   <= acc_in[k][i];
               trunc_ff[k][i] <= trunc_in[k][i];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result formatting: pick quotient or truncated value, restore sign
   // ------------------------------------------------------------------
   result_type         res_in;
   logic [LIMIT_W-1:0] res_mag [WHEELS];

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         res_mag[i] = scale_ff[DIV_STEPS] ? acc_ff[DIV_STEPS][i] : trunc_ff[DIV_STEPS][i];
         res_in.wheel[i] = neg_ff[DIV_STEPS][i] ? WHEEL_W'(-{1'b0, res_mag[i]})
                                                : WHEEL_W'({1'b0, res_mag[i]});
      end
      res_in.was_scaled = scale_ff[DIV_STEPS];
   end

   // ------------------------------------------------------------------
   // Output register and skid entry
   // ------------------------------------------------------------------
   logic       last_valid;
   logic       pop;
   logic       out_valid_ff;
   result_type out_ff;
   result_type skid_ff;

   assign last_valid = dv_ff[DIV_STEPS];
   assign pop        = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // pipeline is held; drain the skid entry once the response moves
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= last_valid;
      end else if (last_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || pop) begin
         out_ff <= res_in;
      end else if (last_valid) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_wheel_one   = $signed(out_ff.wheel[0]);
   assign rsp_wheel_two   = $signed(out_ff.wheel[1]);
   assign rsp_wheel_three = $signed(out_ff.wheel[2]);
   assign rsp_wheel_four  = $signed(out_ff.wheel[3]);
   assign rsp_was_scaled  = out_ff.was_scaled;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   logic signed [WHEEL_W-1:0] limit_pos;
   logic signed [WHEEL_W-1:0] limit_neg;

   assign limit_pos = $signed({1'b0, speed_limit_ff});
   assign limit_neg = -limit_pos;

   // the skid entry only fills behind a waiting response
   `MWM_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

   // a finished result that cannot enter the stalled output lands in the skid
   `MWM_ASSERT_NXT(a_skid_catches, clock, reset,
      out_valid_ff && rsp_stall && !skid_valid_ff && last_valid, skid_valid_ff)

   // every wheel stays within the limit
   `MWM_ASSERT_IMP(a_within_limit, clock, reset, rsp_valid,
      rsp_wheel_one <= limit_pos && rsp_wheel_one >= limit_neg &&
      rsp_wheel_two <= limit_pos && rsp_wheel_two >= limit_neg &&
      rsp_wheel_three <= limit_pos && rsp_wheel_three >= limit_neg &&
      rsp_wheel_four <= limit_pos && rsp_wheel_four >= limit_neg)

   // scaling puts the largest wheel exactly on the limit
   `MWM_ASSERT_IMP(a_scaled_hits_limit, clock, reset, rsp_valid && rsp_was_scaled,
      rsp_wheel_one == limit_pos || rsp_wheel_one == limit_neg ||
      rsp_wheel_two == limit_pos || rsp_wheel_two == limit_neg ||
      rsp_wheel_three == limit_pos || rsp_wheel_three == limit_neg ||
      rsp_wheel_four == limit_pos || rsp_wheel_four == limit_neg)

endmodule
